// ===== hw/rtl/eepc_pkg.sv =====
// Shared types and constants for the electron energy polynomial correction.
package eepc_pkg;

  localparam int ELECTRON_CODE = 11;
  localparam int COEF_FRAC     = 24;

  // Accumulator: signed, saturating at +-2^61, 24 fraction bits.
  typedef logic signed [62:0] acc_t;
  localparam acc_t       ACC_LIM   = 63'sh2000000000000000;
  localparam logic [93:0] ACC_LIM94 = 94'h2000000000000000;
  localparam logic [61:0] ACC_LIM62 = 62'h2000000000000000;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_MASS  = 3'd0,
    REG_COEF0 = 3'd1,
    REG_COEF1 = 3'd2,
    REG_COEF2 = 3'd3,
    REG_COEF3 = 3'd4,
    REG_COEF4 = 3'd5
  } reg_idx_t;

  // Per-request data that travels down the pipeline alongside the arithmetic.
  typedef struct packed {
    logic               corr;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [31:0]        rho;
    logic [31:0]        e;
    logic signed [31:0] en;
  } item_t;

endpackage

// ===== hw/rtl/electron_energy_polynomial_correction.sv =====
// Top level of the electron energy polynomial correction pipeline.

// A request is taken at every rising edge where start is high and busy is low;
// busy never rises, so one particle may be issued every clock cycle. Each
// result is marked by done, high for exactly one cycle per result, and results
// leave in request order. The pipeline is made of the front end (4 stages),
// two 32-bit square roots worked two bits per stage (16), four Horner steps
// of five stages each plus conversion (23) and three lane-parallel 64-by-32
// long divisions, two quotient bits per stage (21).
// The receiver cannot stall the block, so results must be taken as they come.
// Configuration writes should only be issued while no request is in flight.
module electron_energy_polynomial_correction #(
  parameter int MOM_FRAC_BITS = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] particle_code,
  input  logic signed [31:0] mom_x,
  input  logic signed [31:0] mom_y,
  input  logic signed [31:0] mom_z,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic signed [31:0] new_x,
  output logic signed [31:0] new_y,
  output logic signed [31:0] new_z,
  output logic signed [31:0] new_energy,
  output logic               corrected
);

  // The pipeline takes a new request every cycle.
  assign busy = 1'b0;

  // Configuration registers.
  logic [19:0]        mass;
  logic signed [31:0] coef0, coef1, coef2, coef3, coef4;

  always_ff @(posedge clk) begin
    if (rst) begin
      mass  <= 20'd536;
      coef0 <= 32'sd350513;
      coef1 <= 32'sd841512;
      coef2 <= -32'sd303847;
      coef3 <= 32'sd51283;
      coef4 <= -32'sd2990;
    end else if (cfg_we) begin
      unique case (cfg_index)
        eepc_pkg::REG_MASS:  mass  <= cfg_data[19:0];
        eepc_pkg::REG_COEF0: coef0 <= $signed(cfg_data);
        eepc_pkg::REG_COEF1: coef1 <= $signed(cfg_data);
        eepc_pkg::REG_COEF2: coef2 <= $signed(cfg_data);
        eepc_pkg::REG_COEF3: coef3 <= $signed(cfg_data);
        eepc_pkg::REG_COEF4: coef4 <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Front end: capture, magnitudes, squares, then the two radicands
  // |p|^2 and |p|^2 + mass^2.
  logic               v0, v1, v2, v3;
  logic signed [31:0] code0;
  logic signed [31:0] p0 [3];
  logic [31:0]        ap1 [3];
  logic [63:0]        sq2 [3];
  logic [39:0]        ms2;
  logic [63:0]        s3, se3;
  eepc_pkg::item_t    it1, it2, it3, it1_next;

  // Only an electron with some nonzero momentum component is corrected.
  always_comb begin
    it1_next      = '0;
    it1_next.px   = p0[0];
    it1_next.py   = p0[1];
    it1_next.pz   = p0[2];
    it1_next.corr = (code0 == 32'(eepc_pkg::ELECTRON_CODE))
                    && (p0[0] != 32'sd0 || p0[1] != 32'sd0 || p0[2] != 32'sd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v0 <= start & ~busy;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
    code0 <= particle_code;
    p0[0] <= mom_x;
    p0[1] <= mom_y;
    p0[2] <= mom_z;
    it1   <= it1_next;
    for (int i = 0; i < 3; i++) begin
      ap1[i] <= 32'(p0[i][31] ? -p0[i] : p0[i]);
      sq2[i] <= 64'(ap1[i]) * 64'(ap1[i]);
    end
    ms2 <= 40'(mass) * 40'(mass);
    it2 <= it1;
    s3  <= sq2[0] + sq2[1] + sq2[2];
    se3 <= sq2[0] + sq2[1] + sq2[2] + 64'(ms2);
    it3 <= it2;
  end

  // Norm rho and energy E.
  logic            sv;
  eepc_pkg::item_t si;

  eepc_sqrt u_sqrt (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (v3),
    .rad_norm   (s3),
    .rad_energy (se3),
    .in_item    (it3),
    .out_valid  (sv),
    .out_item   (si)
  );

  // Corrected energy from the quartic polynomial.
  logic            hv;
  eepc_pkg::item_t hi;

  eepc_horner #(.FRAC(MOM_FRAC_BITS)) u_horner (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sv),
    .in_item   (si),
    .coef0     (coef0),
    .coef1     (coef1),
    .coef2     (coef2),
    .coef3     (coef3),
    .coef4     (coef4),
    .out_valid (hv),
    .out_item  (hi)
  );

  // Momentum rescaling and output registers.
  eepc_divide u_divide (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (hv),
    .in_item    (hi),
    .done       (done),
    .new_x      (new_x),
    .new_y      (new_y),
    .new_z      (new_z),
    .new_energy (new_energy),
    .corrected  (corrected)
  );

`ifndef SYNTHESIS
  a_corr_done: assert property (@(posedge clk) disable iff (rst)
    corrected |-> done)
    else $error("corrected flag raised without a result strobe");

  a_pass_energy: assert property (@(posedge clk) disable iff (rst)
    done && !corrected |-> new_energy == 32'sd0)
    else $error("passed-through result carries a nonzero energy");

  a_mass_write: assert property (@(posedge clk) disable iff (rst)
    cfg_we && cfg_index == eepc_pkg::REG_MASS |=> mass == $past(cfg_data[19:0]))
    else $error("mass register did not take the written value");
`endif

endmodule

// ===== hw/rtl/eepc_sqrt.sv =====
// Pipelined restoring square roots of the momentum norm and energy radicands.
module eepc_sqrt (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [63:0]       rad_norm,
  input  logic [63:0]       rad_energy,
  input  eepc_pkg::item_t   in_item,
  output logic              out_valid,
  output eepc_pkg::item_t   out_item
);

  localparam int STAGES = 16;
  localparam int STEPS  = 2;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
  } sq_t;

  function automatic sq_t sq_step(input sq_t s);
    logic [35:0] r;
    logic [35:0] t;
    sq_t         o;
    r = {s.rem, s.rad[63:62]};
    t = {2'b00, s.root, 2'b01};
    o.rad = {s.rad[61:0], 2'b00};
    if (r >= t) begin
      o.rem  = 34'(r - t);
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = r[33:0];
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  logic            vld [STAGES];
  eepc_pkg::item_t itm [STAGES];
  sq_t             la  [STAGES];
  sq_t             lb  [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic            sv;
    eepc_pkg::item_t si;
    sq_t             sa;
    sq_t             sb;
    sq_t             na;
    sq_t             nb;

    if (g == 0) begin : g_first
      assign sv = in_valid;
      assign si = in_item;
      assign sa = '{rem: '0, root: '0, rad: rad_norm};
      assign sb = '{rem: '0, root: '0, rad: rad_energy};
    end else begin : g_next
      assign sv = vld[g-1];
      assign si = itm[g-1];
      assign sa = la[g-1];
      assign sb = lb[g-1];
    end

    always_comb begin
      na = sa;
      nb = sb;
      for (int k = 0; k < STEPS; k++) begin
        na = sq_step(na);
        nb = sq_step(nb);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else begin
        vld[g] <= sv;
      end
      itm[g] <= si;
      la[g]  <= na;
      lb[g]  <= nb;
    end
  end

  assign out_valid = vld[STAGES-1];

  always_comb begin
    out_item     = itm[STAGES-1];
    out_item.rho = la[STAGES-1].root;
    out_item.e   = lb[STAGES-1].root;
  end

endmodule

// ===== hw/rtl/eepc_mac.sv =====
// One Horner step: saturating a*E with rounding, then adding a coefficient.
module eepc_mac #(
  parameter int FRAC = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  eepc_pkg::item_t   in_item,
  input  eepc_pkg::acc_t    in_acc,
  input  eepc_pkg::acc_t    coef,
  output logic              out_valid,
  output eepc_pkg::item_t   out_item,
  output eepc_pkg::acc_t    out_acc
);

  localparam logic [93:0]        HALF  = 94'd1 << (FRAC - 1);
  localparam logic signed [63:0] LIM64 = 64'sh2000000000000000;

  logic            v1, v2, v3, v4, v5;
  eepc_pkg::item_t it1, it2, it3, it4, it5;
  logic [61:0]     m1;
  logic            n1, n2, n3;
  logic [62:0]     ph2, pl2;
  logic [93:0]     p3;
  eepc_pkg::acc_t  sr4, sr_next;
  eepc_pkg::acc_t  acc5, acc_next;
  logic [93:0]     rnd;
  logic [61:0]     mag4;
  logic signed [63:0] sum;

  always_comb begin
    rnd  = (p3 + HALF) >> FRAC;
    mag4 = (p3 > eepc_pkg::ACC_LIM94) ? eepc_pkg::ACC_LIM62 : rnd[61:0];
    sr_next = n3 ? -$signed({1'b0, mag4}) : $signed({1'b0, mag4});
  end

  always_comb begin
    sum = 64'(sr4) + 64'(coef);
    if (sum > LIM64) begin
      acc_next = eepc_pkg::ACC_LIM;
    end else if (sum < -LIM64) begin
      acc_next = -eepc_pkg::ACC_LIM;
    end else begin
      acc_next = 63'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
    it1  <= in_item;
    it2  <= it1;
    it3  <= it2;
    it4  <= it3;
    it5  <= it4;
    m1   <= 62'(in_acc[62] ? -in_acc : in_acc);
    n1   <= in_acc[62];
    n2   <= n1;
    n3   <= n2;
    ph2  <= 63'(m1[61:31]) * 63'(it1.e);
    pl2  <= 63'(m1[30:0]) * 63'(it1.e);
    p3   <= {ph2, 31'b0} + 94'(pl2);
    sr4  <= sr_next;
    acc5 <= acc_next;
  end

  assign out_valid = v5;
  assign out_item  = it5;
  assign out_acc   = acc5;

endmodule

// ===== hw/rtl/eepc_horner.sv =====
// Quartic correction of the energy by four Horner steps and a format conversion.
module eepc_horner #(
  parameter int FRAC = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  eepc_pkg::item_t    in_item,
  input  logic signed [31:0] coef0,
  input  logic signed [31:0] coef1,
  input  logic signed [31:0] coef2,
  input  logic signed [31:0] coef3,
  input  logic signed [31:0] coef4,
  output logic               out_valid,
  output eepc_pkg::item_t    out_item
);

  localparam logic [93:0] HALF24 = 94'd1 << (eepc_pkg::COEF_FRAC - 1);

  logic            vch [5];
  eepc_pkg::item_t ich [5];
  eepc_pkg::acc_t  ach [5];
  eepc_pkg::acc_t  step_coef [4];

  assign vch[0] = in_valid;
  assign ich[0] = in_item;
  assign ach[0] = 63'(coef4);

  // The linear term carries the implicit "E plus" of the correction.
  assign step_coef[0] = 63'(coef3);
  assign step_coef[1] = 63'(coef2);
  assign step_coef[2] = 63'(coef1) + (63'sd1 <<< eepc_pkg::COEF_FRAC);
  assign step_coef[3] = 63'(coef0);

  for (genvar k = 0; k < 4; k++) begin : g_step
    eepc_mac #(.FRAC(FRAC)) u_mac (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vch[k]),
      .in_item   (ich[k]),
      .in_acc    (ach[k]),
      .coef      (step_coef[k]),
      .out_valid (vch[k+1]),
      .out_item  (ich[k+1]),
      .out_acc   (ach[k+1])
    );
  end

  logic            c1v, c2v, c3v;
  eepc_pkg::item_t c1i, c2i, c3i, it_next;
  logic [61:0]     c1m, c2m, mag_next;
  logic            c1n, c2n;
  logic [93:0]     shifted, rnd;

  always_comb begin
    shifted  = {32'b0, c1m} << FRAC;
    rnd      = (shifted + HALF24) >> eepc_pkg::COEF_FRAC;
    mag_next = (shifted > eepc_pkg::ACC_LIM94) ? eepc_pkg::ACC_LIM62 : rnd[61:0];
  end

  always_comb begin
    it_next = c2i;
    if (!c2n) begin
      it_next.en = (c2m > 62'h7fffffff) ? 32'sh7fffffff : $signed(c2m[31:0]);
    end else begin
      it_next.en = (c2m > 62'h80000000) ? 32'sh80000000 : -$signed(c2m[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1v <= 1'b0;
      c2v <= 1'b0;
      c3v <= 1'b0;
    end else begin
      c1v <= vch[4];
      c2v <= c1v;
      c3v <= c2v;
    end
    c1i <= ich[4];
    c1m <= 62'(ach[4][62] ? -ach[4] : ach[4]);
    c1n <= ach[4][62];
    c2i <= c1i;
    c2m <= mag_next;
    c2n <= c1n;
    c3i <= it_next;
  end

  assign out_valid = c3v;
  assign out_item  = c3i;

endmodule

// ===== hw/rtl/eepc_divide.sv =====
// Rescales the momentum to the corrected energy: p * E_new / |p| in three lanes.
module eepc_divide (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  eepc_pkg::item_t    in_item,
  output logic               done,
  output logic signed [31:0] new_x,
  output logic signed [31:0] new_y,
  output logic signed [31:0] new_z,
  output logic signed [31:0] new_energy,
  output logic               corrected
);

  localparam int STAGES = 16;
  localparam int STEPS  = 2;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] num;
  } dv_t;

  typedef struct packed {
    eepc_pkg::item_t it;
    logic [2:0]      ng;
    logic [2:0]      sat;
  } dl_t;

  function automatic dv_t dv_step(input dv_t s, input logic [31:0] d);
    logic [32:0] r;
    dv_t         o;
    r = {s.rem, s.num[31]};
    if (r >= {1'b0, d}) begin
      o.rem = 32'(r - {1'b0, d});
      o.num = {s.num[30:0], 1'b1};
    end else begin
      o.rem = r[31:0];
      o.num = {s.num[30:0], 1'b0};
    end
    return o;
  endfunction

  logic signed [31:0] pin [3];
  assign pin[0] = in_item.px;
  assign pin[1] = in_item.py;
  assign pin[2] = in_item.pz;

  logic            v1, v2, v3, v4;
  eepc_pkg::item_t it1, it2, it3;
  logic [31:0]     ap1 [3];
  logic [31:0]     ae1;
  logic [2:0]      ng1, ng2, ng3;
  logic [63:0]     m2  [3];
  logic [63:0]     n3  [3];
  dl_t             dl4;
  dv_t             lv4 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    it1 <= in_item;
    it2 <= it1;
    it3 <= it2;
    ae1 <= 32'(in_item.en[31] ? -in_item.en : in_item.en);
    ng2 <= ng1;
    ng3 <= ng2;
    for (int i = 0; i < 3; i++) begin
      ap1[i] <= 32'(pin[i][31] ? -pin[i] : pin[i]);
      ng1[i] <= pin[i][31] ^ in_item.en[31];
      m2[i]  <= 64'(ap1[i]) * 64'(ae1);
      n3[i]  <= m2[i] + {33'b0, it2.rho[31:1]};
      dl4.sat[i] <= n3[i][63:32] >= it3.rho;
      lv4[i] <= '{rem: n3[i][63:32], num: n3[i][31:0]};
    end
    dl4.it <= it3;
    dl4.ng <= ng3;
  end

  logic vq [STAGES];
  dl_t  dq [STAGES];
  dv_t  lq [STAGES][3];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic sv;
    dl_t  sd;
    dv_t  sl [3];
    dv_t  nl [3];

    if (g == 0) begin : g_first
      assign sv = v4;
      assign sd = dl4;
      assign sl = lv4;
    end else begin : g_next
      assign sv = vq[g-1];
      assign sd = dq[g-1];
      assign sl = lq[g-1];
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        nl[i] = sl[i];
        for (int k = 0; k < STEPS; k++) begin
          nl[i] = dv_step(nl[i], sd.it.rho);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[g] <= 1'b0;
      end else begin
        vq[g] <= sv;
      end
      dq[g] <= sd;
      for (int i = 0; i < 3; i++) begin
        lq[g][i] <= nl[i];
      end
    end
  end

  // Quotient magnitude is capped at 2^31, then signed and saturated.
  logic signed [31:0] val [3];
  dl_t                fin;

  assign fin = dq[STAGES-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [31:0] q;
      q = lq[STAGES-1][i].num;
      if (fin.sat[i] || q > 32'h80000000) begin
        q = 32'h80000000;
      end
      if (fin.ng[i]) begin
        val[i] = -$signed(q);
      end else if (q == 32'h80000000) begin
        val[i] = 32'sh7fffffff;
      end else begin
        val[i] = $signed(q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= 1'b0;
      corrected <= 1'b0;
    end else begin
      done      <= vq[STAGES-1];
      corrected <= vq[STAGES-1] & fin.it.corr;
    end
    new_x      <= fin.it.corr ? val[0] : fin.it.px;
    new_y      <= fin.it.corr ? val[1] : fin.it.py;
    new_z      <= fin.it.corr ? val[2] : fin.it.pz;
    new_energy <= fin.it.corr ? fin.it.en : 32'sd0;
  end

endmodule

// ===== tb/sv/eepc_checker.sv =====
// Checker for the electron energy correction: predicts each result and compares it.
`timescale 1ns / 100ps

module eepc_checker #(
  parameter int MOM_FRAC_BITS = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] particle_code,
  input  logic signed [31:0] mom_x,
  input  logic signed [31:0] mom_y,
  input  logic signed [31:0] mom_z,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               done,
  input  logic signed [31:0] new_x,
  input  logic signed [31:0] new_y,
  input  logic signed [31:0] new_z,
  input  logic signed [31:0] new_energy,
  input  logic               corrected,
  output int                 errors,
  output int                 pending
);

  localparam longint LIM = longint'(1) <<< 61;

  typedef struct {
    logic signed [31:0] x, y, z, en;
    logic               corr;
  } particle_out_t;

  logic [19:0]  mass_q;
  longint       c0, c1, c2, c3, c4;
  particle_out_t corrected_q[$];

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint clamp61(input longint v);
    if (v > LIM) return LIM;
    if (v < -LIM) return -LIM;
    return v;
  endfunction

  // Rounded (a * e) >> sh, ties away from zero, saturating at the accumulator limit.
  function automatic longint scale_round(input longint a, input logic [63:0] e, input int sh);
    logic [63:0] m, r;
    m = (a < 0) ? -a : a;
    if (e != 0 && m > 64'(LIM) / e) r = 64'(LIM);
    else r = (m * e + (64'd1 << (sh - 1))) >> sh;
    return (a < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic signed [31:0] sat32(input longint v);
    if (v > 64'sh7fffffff) return 32'sh7fffffff;
    if (v < -64'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic particle_out_t correct_particle(input logic signed [31:0] code,
      input logic signed [31:0] px, input logic signed [31:0] py, input logic signed [31:0] pz);
    particle_out_t o;
    logic [63:0] s, rho, e, m, q, mp, me;
    longint a, en;
    logic signed [31:0] p[3];
    p[0] = px; p[1] = py; p[2] = pz;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      mp = (p[i] < 0) ? -longint'(p[i]) : longint'(p[i]);
      s = s + mp * mp;
    end
    if (code != eepc_pkg::ELECTRON_CODE || s == 0) begin
      o.x = px; o.y = py; o.z = pz; o.en = 0; o.corr = 1'b0;
      return o;
    end
    rho = isqrt(s);
    e = isqrt(s + 64'(mass_q) * 64'(mass_q));
    // Horner evaluation in 24-bit fraction, E carries MOM_FRAC_BITS fraction bits.
    a = c4;
    a = clamp61(scale_round(a, e, MOM_FRAC_BITS) + c3);
    a = clamp61(scale_round(a, e, MOM_FRAC_BITS) + c2);
    a = clamp61(scale_round(a, e, MOM_FRAC_BITS)
                + clamp61(c1 + (longint'(1) <<< eepc_pkg::COEF_FRAC)));
    a = clamp61(scale_round(a, e, MOM_FRAC_BITS) + c0);
    en = sat32(scale_round(a, 64'd1 << MOM_FRAC_BITS, eepc_pkg::COEF_FRAC));
    me = (en < 0) ? -en : en;
    for (int i = 0; i < 3; i++) begin
      mp = (p[i] < 0) ? -longint'(p[i]) : longint'(p[i]);
      m = mp * me;
      q = (m + rho / 2) / rho;
      if (q > (64'd1 << 31)) q = 64'd1 << 31;
      p[i] = sat32(((p[i] < 0) != (en < 0)) ? -longint'(q) : longint'(q));
    end
    o.x = p[0]; o.y = p[1]; o.z = p[2]; o.en = en[31:0]; o.corr = 1'b1;
    return o;
  endfunction

  always @(posedge clk) begin
    particle_out_t want;
    int bad;
    bad = 0;
    if (rst) begin
      mass_q <= 20'd536;
      c0 = 350513; c1 = 841512; c2 = -303847; c3 = 51283; c4 = -2990;
      errors <= 0;
      pending <= 0;
      corrected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          eepc_pkg::REG_MASS:  mass_q <= cfg_data[19:0];
          eepc_pkg::REG_COEF0: c0 = longint'(signed'(cfg_data));
          eepc_pkg::REG_COEF1: c1 = longint'(signed'(cfg_data));
          eepc_pkg::REG_COEF2: c2 = longint'(signed'(cfg_data));
          eepc_pkg::REG_COEF3: c3 = longint'(signed'(cfg_data));
          eepc_pkg::REG_COEF4: c4 = longint'(signed'(cfg_data));
          default: ;
        endcase
      end
      if (start && !busy)
        corrected_q.push_back(correct_particle(particle_code, mom_x, mom_y, mom_z));
      if (done) begin
        if (corrected_q.size() == 0) begin
          $error("result with no request outstanding");
          bad++;
        end else begin
          want = corrected_q.pop_front();
          if (new_x !== want.x) begin
            $error("new_x: expected %0d, got %0d", want.x, new_x); bad++;
          end
          if (new_y !== want.y) begin
            $error("new_y: expected %0d, got %0d", want.y, new_y); bad++;
          end
          if (new_z !== want.z) begin
            $error("new_z: expected %0d, got %0d", want.z, new_z); bad++;
          end
          if (new_energy !== want.en) begin
            $error("new_energy: expected %0d, got %0d", want.en, new_energy);
            bad++;
          end
          if (corrected !== want.corr) begin
            $error("corrected: expected %0b, got %0b", want.corr, corrected);
            bad++;
          end
        end
      end
      errors <= errors + bad;
      pending <= corrected_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the testbench: stimulus, configuration phases and the final verdict.
`timescale 1ns / 100ps

module tb_top;

  // Extra cycles to let pass once every result is back, before touching the
  // coefficient registers.
  localparam int SETTLE   = 72;
  // No accepted request or result for this many cycles means the block hung.
  localparam int WATCHDOG = 1000;
  // Register indexes the block does not implement; writes there are ignored.
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, corrected;
  logic signed [31:0] particle_code = 0, mom_x = 0, mom_y = 0, mom_z = 0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = eepc_pkg::REG_MASS;
  logic [31:0] cfg_data = 0;
  logic signed [31:0] new_x, new_y, new_z, new_energy;
  int errors, pending;
  int quiet_cycles = 0;
  bit no_gaps;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  electron_energy_polynomial_correction dut (.*);

  eepc_checker chk (.*);

  // Watchdog: any accepted request or delivered result counts as progress.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Sends one request: an optional random gap with start low, then the item is
  // held at the ports until the block takes it.
  task automatic send_particle(input logic [31:0] code, input logic [31:0] px,
      input logic [31:0] py, input logic [31:0] pz);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    particle_code <= code;
    mom_x <= px;
    mom_y <= py;
    mom_z <= pz;
    do @(posedge clk); while (busy);
  endtask

  // Lowers start and waits until every outstanding request has come back.
  task automatic drain;
    @(negedge clk) start <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  // Loads the whole coefficient set, then drops the write enable.
  task automatic load_coefs(input logic [31:0] m, input logic [31:0] k0, input logic [31:0] k1,
      input logic [31:0] k2, input logic [31:0] k3, input logic [31:0] k4);
    write_reg(eepc_pkg::REG_MASS, m);
    write_reg(eepc_pkg::REG_COEF0, k0);
    write_reg(eepc_pkg::REG_COEF1, k1);
    write_reg(eepc_pkg::REG_COEF2, k2);
    write_reg(eepc_pkg::REG_COEF3, k3);
    write_reg(eepc_pkg::REG_COEF4, k4);
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  // Momentum component with a random magnitude scale, so that small, typical
  // and huge momenta all turn up; now and then a full random word or an extreme.
  function automatic logic [31:0] rand_mom();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = $urandom();
      1: v = ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
      2: v = 0;
      default: begin
        v = $urandom() >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) != 0) v = -v;
      end
    endcase
    return v;
  endfunction

  // Mostly electrons; the rest are other species including the antiparticle.
  function automatic logic [31:0] rand_code();
    case ($urandom_range(0, 9))
      0: return -eepc_pkg::ELECTRON_CODE;
      1: return $urandom();
      2: return $urandom_range(0, 30);
      default: return eepc_pkg::ELECTRON_CODE;
    endcase
  endfunction

  // Random request block under the current coefficients.
  task automatic random_burst(input int count);
    for (int i = 0; i < count; i++) begin
      // Every so often switch between back-to-back streaming and gappy traffic.
      if (i % 20 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_particle(rand_code(), rand_mom(), rand_mom(), rand_mom());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed requests under the reset coefficients.
    no_gaps = 1'b0;
    send_particle(eepc_pkg::ELECTRON_CODE, 32'd1 << 20, 0, 0);
    send_particle(eepc_pkg::ELECTRON_CODE, 0, 0, 0);
    send_particle(-eepc_pkg::ELECTRON_CODE, 32'd5 << 20, 32'd3, -32'd7);
    send_particle(32'd22, 32'h7fffffff, 32'h80000000, 32'h12345678);
    send_particle(32'h80000000, 32'hffffffff, 32'h00000001, 0);
    send_particle(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000);
    send_particle(eepc_pkg::ELECTRON_CODE, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_particle(eepc_pkg::ELECTRON_CODE, 32'h80000000, 32'h80000000, 32'h80000000);
    send_particle(eepc_pkg::ELECTRON_CODE, 32'h80000000, 0, 0);
    send_particle(eepc_pkg::ELECTRON_CODE, 0, -32'd1, 0);
    send_particle(eepc_pkg::ELECTRON_CODE, 0, 0, 32'd1);
    send_particle(eepc_pkg::ELECTRON_CODE, 32'd3 << 20, -(32'd4 << 20), 32'd12 << 20);
    send_particle(eepc_pkg::ELECTRON_CODE, 32'd10 << 20, 32'd10 << 20, -(32'd1 << 19));
    drain();

    // Coefficients that drive the energy negative: momenta come out reversed.
    load_coefs(32'd536, -(32'd50 << 24), 0, 0, 0, 0);
    write_reg(REG_SPARE_A, 32'hffffffff);
    write_reg(REG_SPARE_B, 32'h00000000);
    @(negedge clk) cfg_we <= 1'b0;
    send_particle(eepc_pkg::ELECTRON_CODE, 32'd1 << 20, 32'd2 << 20, -(32'd2 << 20));
    send_particle(eepc_pkg::ELECTRON_CODE, 32'd7, 0, 0);
    random_burst(40);
    drain();

    // Extreme coefficients and full mass: the polynomial saturates.
    load_coefs(32'hfffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_particle(eepc_pkg::ELECTRON_CODE, 0, 0, 32'd1);
    send_particle(eepc_pkg::ELECTRON_CODE, 32'h7fffffff, 0, 0);
    random_burst(40);
    drain();

    load_coefs(32'h0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    random_burst(40);
    drain();

    // All coefficients zero: the energy is left alone.
    load_coefs(32'h0, 0, 0, 0, 0, 0);
    random_burst(40);
    drain();

    // Several random sets, including full-width words for every register bit.
    for (int s = 0; s < 4; s++) begin
      if (s < 2)
        load_coefs($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      else
        load_coefs($urandom_range(0, 4000), $urandom_range(0, 1 << 22) - (1 << 21),
                   $urandom_range(0, 1 << 21) - (1 << 20), $urandom_range(0, 1 << 20) - (1 << 19),
                   $urandom_range(0, 1 << 17) - (1 << 16), $urandom_range(0, 1 << 13) - (1 << 12));
      random_burst(40);
      drain();
    end

    // Back to the reset values for a long realistic stretch.
    load_coefs(32'd536, 32'd350513, 32'd841512, -32'd303847, 32'd51283, -32'd2990);
    random_burst(60);
    drain();

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
